@@ sv/sawcl_pkg.sv @@
// Shared types and constants of the set-associative cache tag lookup.
package sawcl_pkg;

  localparam int unsigned TAG_W      = 32;
  localparam int unsigned SET_IDX_W  = 8;
  localparam int unsigned WAYS_CFG_W = 4;
  localparam int unsigned OUT_WAY_W  = 3;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic OP_WRITE   = 1'b1;
  localparam logic POLICY_LRU = 1'b0;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_WAYS   = 2'd1;
  localparam logic [1:0] REG_NEXT   = 2'd2;

  localparam logic                  POLICY_RST = POLICY_LRU;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST   = 4'd8;
  localparam logic                  NEXT_RST   = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [SET_IDX_W-1:0] set_index;
    logic [TAG_W-1:0]     tag;
  } item_t;

  typedef struct packed {
    logic                  replace_policy;
    logic [WAYS_CFG_W-1:0] ways_in_use;
    logic                  next_level_present;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 victim_dirty;
    logic                 writeback_request;
    logic [TAG_W-1:0]     writeback_tag;
    logic                 fill_request;
  } result_t;

endpackage

@@ sv/sawcl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sawcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sawcl_regs.sv @@
// APB configuration registers of the cache tag lookup.
module sawcl_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sawcl_pkg::PADDR_W-1:0]       paddr,
  input  logic [sawcl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sawcl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output sawcl_pkg::cfg_t                     cfg_o
);
  import sawcl_pkg::*;

  logic                  policy_q;
  logic [WAYS_CFG_W-1:0] ways_q;
  logic                  next_q;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RST;
      ways_q   <= WAYS_RST;
      next_q   <= NEXT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POLICY: policy_q <= pwdata[0];
        REG_WAYS:   ways_q   <= pwdata[WAYS_CFG_W-1:0];
        REG_NEXT:   next_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POLICY: prdata = {{(APB_DATA_W-1){1'b0}}, policy_q};
      REG_WAYS:   prdata = {{(APB_DATA_W-WAYS_CFG_W){1'b0}}, ways_q};
      REG_NEXT:   prdata = {{(APB_DATA_W-1){1'b0}}, next_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.replace_policy     = policy_q;
  assign cfg_o.ways_in_use        = ways_q;
  assign cfg_o.next_level_present = next_q;

endmodule

@@ sv/sawcl_front.sv @@
// Front end: accepts access items, wraps the set index and queues them.
module sawcl_front #(
  parameter int unsigned SETS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clearing_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [sawcl_pkg::SET_IDX_W-1:0]     set_index_i,
  input  logic [sawcl_pkg::TAG_W-1:0]         tag_i,
  output logic                                q_valid_o,
  input  logic                                q_pop_i,
  output sawcl_pkg::item_t                    q_item_o
);
  import sawcl_pkg::*;

  localparam int unsigned NIDX = 2 ** SET_IDX_W;

  logic [SET_IDX_W-1:0] wrap_tab [NIDX];
  item_t                ent_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q, cnt_d;
  logic                 push, pop;
  item_t                new_item;

  // set index modulo SETS, folded into a constant table
  for (genvar g = 0; g < NIDX; g++) begin : g_wrap
    assign wrap_tab[g] = SET_IDX_W'(g % SETS);
  end

  assign new_item.operation = operation_i;
  assign new_item.set_index = wrap_tab[set_index_i];
  assign new_item.tag       = tag_i;

  assign in_ready_o = (cnt_q != 2'd2) && !clearing_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = ent_q[rd_ptr_q];
  assign cnt_d      = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

@@ sv/sawcl_back.sv @@
// Back end: reads a set's row, resolves hit or victim, writes the row back.
module sawcl_back #(
  parameter int unsigned SETS = 256,
  parameter int unsigned WAYS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sawcl_pkg::cfg_t      cfg_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  sawcl_pkg::item_t     q_item_i,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sawcl_pkg::result_t   result_o
);
  import sawcl_pkg::*;

  localparam int unsigned ROWS = (SETS < 256) ? SETS : 256;
  localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned NW   = ($clog2(WAYS + 1) > WAYS_CFG_W) ?
                                 $clog2(WAYS + 1) : WAYS_CFG_W;
  localparam int unsigned LW   = 2 + 2 * TAG_W;
  localparam int unsigned RW   = WAYS * LW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  item_t            cur_q, cur_d;
  logic [TAG_W-1:0] cnt_q, cnt_d, cnt_nxt;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr, cur_addr;
  logic [RW-1:0]    ram_wdata, ram_rdata, new_row;

  logic [NW-1:0]    n_eff;
  logic [WAYS-1:0]  vld, drt, act, match, inv, is_min;
  logic [TAG_W-1:0] tg [WAYS];
  logic [TAG_W-1:0] st [WAYS];
  logic [WW-1:0]    hit_way, inv_way, min_way, victim;
  logic             hit, have_inv, vdirty;
  logic             e_vld, e_drt;
  logic [TAG_W-1:0] e_tg, e_st;

  sawcl_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur_addr = AW'(cur_q.set_index);
  assign cnt_nxt  = cnt_q + TAG_W'(1);

  // clamp associativity to 1..WAYS
  always_comb begin
    if (cfg_i.ways_in_use == '0) begin
      n_eff = NW'(1);
    end else if (NW'(cfg_i.ways_in_use) > NW'(WAYS)) begin
      n_eff = NW'(WAYS);
    end else begin
      n_eff = NW'(cfg_i.ways_in_use);
    end
  end

  // per-way fields, tag match and invalid flags
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      {st[w], tg[w], drt[w], vld[w]} = ram_rdata[w*LW +: LW];
      act[w]   = NW'(w) < n_eff;
      match[w] = act[w] && vld[w] && (tg[w] == cur_q.tag);
      inv[w]   = act[w] && !vld[w];
    end
  end

  // oldest stamp: strictly below every lower way, not above any higher way
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      is_min[w] = act[w];
      for (int o = 0; o < WAYS; o++) begin
        if (act[o] && (o < w) && !(st[w] < st[o])) begin
          is_min[w] = 1'b0;
        end
        if (act[o] && (o > w) && (st[o] < st[w])) begin
          is_min[w] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    min_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WW'(w);
      end
      if (inv[w]) begin
        inv_way = WW'(w);
      end
      if (is_min[w]) begin
        min_way = WW'(w);
      end
    end
  end

  assign hit      = |match;
  assign have_inv = |inv;
  assign victim   = have_inv ? inv_way : min_way;
  assign vdirty   = !hit && vld[victim] && drt[victim];

  // updated row: refresh the hit line or refill the victim
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      e_vld = vld[w];
      e_drt = drt[w];
      e_tg  = tg[w];
      e_st  = st[w];
      if (hit) begin
        if (WW'(w) == hit_way) begin
          if (cfg_i.replace_policy == POLICY_LRU) begin
            e_st = cnt_nxt;
          end
          if (cur_q.operation == OP_WRITE) begin
            e_drt = 1'b1;
          end
        end
      end else if (WW'(w) == victim) begin
        e_vld = 1'b1;
        e_drt = (cur_q.operation == OP_WRITE);
        e_tg  = cur_q.tag;
        e_st  = cnt_nxt;
      end
      new_row[w*LW +: LW] = {e_st, e_tg, e_drt, e_vld};
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = AW'(q_item_i.set_index);
    ram_we      = 1'b0;
    ram_waddr   = cur_addr;
    ram_wdata   = new_row;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ram_re  = 1'b1;
          cur_d   = q_item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          ram_we                  = 1'b1;
          out_valid_d             = 1'b1;
          cnt_d                   = cnt_nxt;
          res_d.hit               = hit;
          res_d.way               = OUT_WAY_W'(hit ? hit_way : victim);
          res_d.victim_dirty      = vdirty;
          res_d.writeback_request = vdirty && cfg_i.next_level_present;
          res_d.writeback_tag     = vdirty ? tg[victim] : '0;
          res_d.fill_request      = !hit && cfg_i.next_level_present;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

@@ sv/set_assoc_writeback_cache_lookup.sv @@
// Top level of the set-associative write-back cache tag lookup.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  operation_i, set_index_i, tag_i
//   out      output     out_valid_o/out_ready_i hit_o, way_o, victim_dirty_o,
//                                              writeback_request_o,
//                                              writeback_tag_o, fill_request_o
//   cfg      input      APB psel/penable/pready replace_policy, ways_in_use,
//                                              next_level_present
//
// In the back end an item's set row (tag, stamp, valid, dirty of all ways) is
// read from the line RAM in ST_IDLE; ST_EXEC then resolves hit or victim and
// writes the row back through the same RAM's write port.
// After reset a clearing pass zeroes min(SETS, 256) rows, one row a cycle,
// with in_ready_o low. A two-entry queue keeps the input side taking items
// while the back end works; a full output register stalls the back end.
module set_assoc_writeback_cache_lookup #(
  parameter int unsigned SETS = 256,
  parameter int unsigned WAYS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             operation_i,
  input  logic [sawcl_pkg::SET_IDX_W-1:0]  set_index_i,
  input  logic [sawcl_pkg::TAG_W-1:0]      tag_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [sawcl_pkg::OUT_WAY_W-1:0]  way_o,
  output logic                             victim_dirty_o,
  output logic                             writeback_request_o,
  output logic [sawcl_pkg::TAG_W-1:0]      writeback_tag_o,
  output logic                             fill_request_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sawcl_pkg::PADDR_W-1:0]    paddr,
  input  logic [sawcl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sawcl_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import sawcl_pkg::*;

  cfg_t    cfg;
  item_t   q_item;
  result_t result;
  logic    q_valid, q_pop, clearing;

  sawcl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sawcl_front #(
    .SETS (SETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_i  (clearing),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .set_index_i (set_index_i),
    .tag_i       (tag_i),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_item_o    (q_item)
  );

  sawcl_back #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign hit_o               = result.hit;
  assign way_o               = result.way;
  assign victim_dirty_o      = result.victim_dirty;
  assign writeback_request_o = result.writeback_request;
  assign writeback_tag_o     = result.writeback_tag;
  assign fill_request_o      = result.fill_request;

endmodule

@@ sv/sawcl_checker.sv @@
// Port-level assertions of the cache tag lookup and their bind.
module sawcl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             hit_o,
  input logic [sawcl_pkg::OUT_WAY_W-1:0]  way_o,
  input logic                             victim_dirty_o,
  input logic                             writeback_request_o,
  input logic [sawcl_pkg::TAG_W-1:0]      writeback_tag_o,
  input logic                             fill_request_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({hit_o, way_o, victim_dirty_o, writeback_request_o,
               writeback_tag_o, fill_request_o}))
    else $error("result changed while stalled");

  a_hit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !fill_request_o && !victim_dirty_o &&
      !writeback_request_o && (writeback_tag_o == '0))
    else $error("hit reported a fill or a writeback");

  a_wb_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_request_o |-> victim_dirty_o)
    else $error("writeback requested for a clean victim");

  a_clean_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !victim_dirty_o |-> (writeback_tag_o == '0))
    else $error("writeback tag set without a dirty victim");

  a_wb_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o && writeback_request_o |-> fill_request_o)
    else $error("writeback issued without a fill on a miss");

endmodule

bind set_assoc_writeback_cache_lookup sawcl_checker u_sawcl_checker (.*);

@@ bench/set_assoc_writeback_cache_lookup_tb.sv @@
// Self-checking testbench for the set-associative write-back cache tag lookup.
`timescale 1ns / 100ps

module set_assoc_writeback_cache_lookup_tb;
  import sawcl_pkg::*;

  localparam int unsigned SETS        = 256;
  localparam int unsigned WAYS        = 8;
  localparam int unsigned WATCH_LIMIT = 3000;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT    = 16;

  localparam logic       OP_READ     = ~OP_WRITE;
  localparam logic       POLICY_FIFO = ~POLICY_LRU;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  operation_i = 1'b0;
  logic [SET_IDX_W-1:0]  set_index_i = '0;
  logic [TAG_W-1:0]      tag_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  hit_o;
  logic [OUT_WAY_W-1:0]  way_o;
  logic                  victim_dirty_o;
  logic                  writeback_request_o;
  logic [TAG_W-1:0]      writeback_tag_o;
  logic                  fill_request_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PADDR_W-1:0]    paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  set_assoc_writeback_cache_lookup #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .set_index_i        (set_index_i),
    .tag_i              (tag_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .hit_o              (hit_o),
    .way_o              (way_o),
    .victim_dirty_o     (victim_dirty_o),
    .writeback_request_o(writeback_request_o),
    .writeback_tag_o    (writeback_tag_o),
    .fill_request_o     (fill_request_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the tag store and its configuration
  bit [TAG_W-1:0] cached_tag   [SETS*WAYS];
  bit             cached_valid [SETS*WAYS];
  bit             cached_dirty [SETS*WAYS];
  bit [31:0]      cached_stamp [SETS*WAYS];
  bit [31:0]      access_count = '0;
  cfg_t           cfg = '{replace_policy: POLICY_RST, ways_in_use: WAYS_RST,
                          next_level_present: NEXT_RST};

  item_t   access_queue[$];
  result_t expected_lookups[$];

  int unsigned idle_pct     = IDLE_PCT;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen    = 0;
  int unsigned writebacks   = 0;
  int unsigned settings     = 1;
  int unsigned fails        = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  logic [SET_IDX_W-1:0] hot_set [4];
  logic [TAG_W-1:0]     tag_base;

  function automatic result_t lookup_line(item_t acc);
    int unsigned n, base, w, pick, e;
    bit          found;
    bit          have_free;
    result_t     r;
    n = 32'(cfg.ways_in_use);
    if (n < 1) n = 1;
    if (n > WAYS) n = WAYS;
    base = (acc.set_index % SETS) * WAYS;
    access_count = access_count + 1;
    r = '0;
    found = 1'b0;
    pick = 0;
    for (w = 0; w < n && !found; w++) begin
      if (cached_valid[base+w] && cached_tag[base+w] == acc.tag) begin
        found = 1'b1;
        pick = w;
      end
    end
    if (found) begin
      e = base + pick;
      if (cfg.replace_policy == POLICY_LRU) cached_stamp[e] = access_count;
      if (acc.operation == OP_WRITE) cached_dirty[e] = 1'b1;
      r.hit = 1'b1;
      r.way = pick[OUT_WAY_W-1:0];
      return r;
    end
    // Lowest invalid way first, else oldest stamp with lowest way on ties
    have_free = 1'b0;
    for (w = 0; w < n && !have_free; w++) begin
      if (!cached_valid[base+w]) begin
        have_free = 1'b1;
        pick = w;
      end
    end
    if (!have_free) begin
      pick = 0;
      for (w = 1; w < n; w++) begin
        if (cached_stamp[base+w] < cached_stamp[base+pick]) pick = w;
      end
    end
    e = base + pick;
    if (cached_valid[e] && cached_dirty[e]) begin
      r.victim_dirty  = 1'b1;
      r.writeback_tag = cached_tag[e];
    end
    r.writeback_request = r.victim_dirty & cfg.next_level_present;
    r.fill_request      = cfg.next_level_present;
    r.way               = pick[OUT_WAY_W-1:0];
    cached_tag[e]   = acc.tag;
    cached_stamp[e] = access_count;
    cached_dirty[e] = (acc.operation == OP_WRITE);
    cached_valid[e] = 1'b1;
    return r;
  endfunction

  // Driver: present queued accesses, idling at random between items
  always @(posedge clk_i) begin
    bit offer_next;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer_next = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_lookups.push_back(lookup_line(access_queue.pop_front()));
        items_sent++;
        offer_next = 1'b1;
      end
      if (offer_next) begin
        if (access_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i  <= 1'b1;
          operation_i <= access_queue[0].operation;
          set_index_i <= access_queue[0].set_index;
          tag_i       <= access_queue[0].tag;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fails++;
    end
  endtask

  // Monitor: check each result against the oldest expected lookup
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          $error("result with no access outstanding");
          fails++;
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("way", 32'(want.way), 32'(way_o));
          check_field("victim_dirty", 32'(want.victim_dirty), 32'(victim_dirty_o));
          check_field("writeback_request", 32'(want.writeback_request),
                      32'(writeback_request_o));
          check_field("writeback_tag", want.writeback_tag, writeback_tag_o);
          check_field("fill_request", 32'(want.fill_request), 32'(fill_request_o));
          results_seen++;
          if (want.hit) hits_seen++;
          if (want.victim_dirty) writebacks++;
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (results_seen == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("set_assoc_writeback_cache_lookup_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_POLICY: cfg.replace_policy     = value[0];
      REG_WAYS:   cfg.ways_in_use        = value[WAYS_CFG_W-1:0];
      REG_NEXT:   cfg.next_level_present = value[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_access(logic op, logic [SET_IDX_W-1:0] set, logic [TAG_W-1:0] tag);
    item_t it;
    it.operation = op;
    it.set_index = set;
    it.tag       = tag;
    access_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (access_queue.size() != 0 || expected_lookups.size() != 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  // Mostly hot sets with a small tag pool, the rest anywhere in the space
  task automatic push_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85)
        push_access(1'($urandom_range(1)), hot_set[2'($urandom_range(3))],
                    tag_base + TAG_W'($urandom_range(11)));
      else
        push_access(1'($urandom_range(1)), SET_IDX_W'($urandom_range(255)),
                    TAG_W'($urandom));
    end
  endtask

  task automatic run_phase(logic policy, logic [WAYS_CFG_W-1:0] ways, logic nl,
                           int unsigned count, bit fresh_sets);
    write_reg(REG_POLICY, {31'd0, policy});
    write_reg(REG_WAYS, {28'd0, ways});
    write_reg(REG_NEXT, {31'd0, nl});
    settings++;
    if (fresh_sets) begin
      foreach (hot_set[i]) hot_set[i] = SET_IDX_W'($urandom_range(255));
      tag_base = $urandom;
    end
    push_random(count);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill, hit, dirty eviction and the field extremes
    push_access(OP_READ, 8'd0, 32'd0);
    push_access(OP_READ, 8'd0, 32'd0);
    push_access(OP_WRITE, 8'd0, 32'd0);
    for (int unsigned t = 1; t < WAYS; t++) push_access(t[0], 8'd0, t);
    push_access(OP_READ, 8'd0, 32'hFFFF_FFFF);
    push_access(OP_WRITE, 8'd0, 32'd1);
    push_access(OP_READ, 8'd0, 32'd0);
    push_access(OP_READ, 8'd255, 32'hFFFF_FFFF);
    push_access(OP_WRITE, 8'd255, 32'hFFFF_FFFF);
    push_access(OP_WRITE, 8'd170, 32'hAAAA_AAAA);
    push_access(OP_READ, 8'd85, 32'h5555_5555);
    wait_drained();

    foreach (hot_set[i]) hot_set[i] = SET_IDX_W'($urandom_range(255));
    tag_base = $urandom;
    push_random(100);
    wait_drained();

    run_phase(POLICY_FIFO, 4'd8, 1'b1, 100, 1'b1);
    run_phase(POLICY_LRU, 4'd1, 1'b0, 70, 1'b1);
    run_phase(POLICY_FIFO, 4'd4, 1'b0, 80, 1'b1);
    run_phase(POLICY_LRU, 4'd0, 1'b1, 50, 1'b1);
    run_phase(POLICY_FIFO, 4'd15, 1'b1, 80, 1'b1);
    idle_pct = 0;
    run_phase(POLICY_LRU, 4'd3, 1'b1, 80, 1'b1);
    // Grow back to all ways over the same sets; the spare address is ignored
    write_reg(REG_SPARE, 32'd1);
    run_phase(POLICY_LRU, 4'd8, 1'b1, 80, 1'b0);
    idle_pct = IDLE_PCT;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d accesses over %0d register settings: %0d hits, %0d dirty evictions",
             items_sent, settings, hits_seen, writebacks);
    $display("LRU and FIFO, 0 to 15 ways requested, next level on and off, one long output stall");
    if (fails == 0 && expected_lookups.size() == 0)
      $display("set_assoc_writeback_cache_lookup_tb OK");
    else
      $display("set_assoc_writeback_cache_lookup_tb NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
sv/sawcl_pkg.sv
sv/sawcl_ram.sv
sv/sawcl_regs.sv
sv/sawcl_front.sv
sv/sawcl_back.sv
sv/set_assoc_writeback_cache_lookup.sv
sv/sawcl_checker.sv
bench/set_assoc_writeback_cache_lookup_tb.sv
